// File: src/cnc_msh_pkg.sv
// shared types and codes for the cnc machine-state and homing block
`default_nettype none
package cnc_msh_pkg;

	localparam int unsigned AXIS_W   = 6;
	localparam int unsigned AIDX_W   = 3;
	localparam int unsigned POS_W    = 32;
	localparam int unsigned RATE_W   = 20;
	localparam int unsigned PULL_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [RATE_W-1:0] DEFAULT_SEEK    = 20'd1000;
	localparam logic [RATE_W-1:0] DEFAULT_FEED    = 20'd100;
	localparam logic [PULL_W-1:0] DEFAULT_PULLOFF = 16'd200;

	// event codes
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_ESTOP  = 3'd1;
	localparam logic [2:0] OP_RESET  = 3'd2;
	localparam logic [2:0] OP_HOLD   = 3'd3;
	localparam logic [2:0] OP_RESUME = 3'd4;
	localparam logic [2:0] OP_HOME   = 3'd5;

	// reported machine state codes
	localparam logic [2:0] MS_IDLE   = 3'd0;
	localparam logic [2:0] MS_RUN    = 3'd1;
	localparam logic [2:0] MS_HOLD   = 3'd2;
	localparam logic [2:0] MS_HOMING = 3'd3;
	localparam logic [2:0] MS_ESTOP  = 3'd4;

	localparam logic [1:0] JOG_NONE  = 2'd0;
	localparam logic [1:0] JOG_START = 2'd1;
	localparam logic [1:0] JOG_STOP  = 2'd2;

	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_ESTOP  = 3'd1;
	localparam logic [2:0] CMD_RESET  = 3'd2;
	localparam logic [2:0] CMD_HOLD   = 3'd3;
	localparam logic [2:0] CMD_RESUME = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOME_DIR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEEK     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FEED     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PULLOFF  = 2'd3;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_RUN    = 5'b00010,
		MODE_HOLD   = 5'b00100,
		MODE_HOMING = 5'b01000,
		MODE_ESTOP  = 5'b10000
	} mode_t;

	typedef enum logic [3:0] {
		PH_SELECT = 4'b0001,
		PH_FAST   = 4'b0010,
		PH_BACKOFF = 4'b0100,
		PH_SLOW   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [2:0]        operation;
		logic [AXIS_W-1:0] home_axes;
		logic [AXIS_W-1:0] limit_switches;
		logic [POS_W-1:0]  jog_axis_position;
		logic              stepper_stopped_hard;
		logic              stepper_done;
		logic              segment_ready;
	} item_t;

	typedef struct packed {
		logic [2:0]        machine_state;
		logic [1:0]        jog_action;
		logic [AIDX_W-1:0] jog_axis;
		logic              jog_positive;
		logic [RATE_W-1:0] jog_rate;
		logic              load_segment;
		logic [2:0]        stepper_command;
		logic              clear_queue;
		logic              zero_positions;
		logic              home_done;
		logic              home_success;
		logic [AXIS_W-1:0] home_done_mask;
	} result_t;

	// effective settings, zero already replaced by the defaults
	typedef struct packed {
		logic [AXIS_W-1:0] home_dir;
		logic [RATE_W-1:0] fast_rate;
		logic [RATE_W-1:0] slow_rate;
		logic [PULL_W-1:0] pulloff;
	} cfg_t;

endpackage
`default_nettype wire

// File: src/cnc_msh_cfg.sv
// configuration registers with zero-selects-default handling
`default_nettype none
module cnc_msh_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [cnc_msh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [cnc_msh_pkg::RATE_W-1:0]      cfg_data,
	output cnc_msh_pkg::cfg_t                        cfg
);
	import cnc_msh_pkg::*;

	logic [AXIS_W-1:0] home_dir_q;
	logic [RATE_W-1:0] seek_q;
	logic [RATE_W-1:0] feed_q;
	logic [PULL_W-1:0] pull_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_dir_q <= '0;
			seek_q     <= DEFAULT_SEEK;
			feed_q     <= DEFAULT_FEED;
			pull_q     <= DEFAULT_PULLOFF;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HOME_DIR: home_dir_q <= cfg_data[AXIS_W-1:0];
				REG_SEEK:     seek_q     <= cfg_data;
				REG_FEED:     feed_q     <= cfg_data;
				REG_PULLOFF:  pull_q     <= cfg_data[PULL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.home_dir  = home_dir_q;
	assign cfg.fast_rate = (seek_q == '0) ? DEFAULT_SEEK : seek_q;
	assign cfg.slow_rate = (feed_q == '0) ? DEFAULT_FEED : feed_q;
	assign cfg.pulloff   = (pull_q == '0) ? DEFAULT_PULLOFF : pull_q;

endmodule
`default_nettype wire

// File: src/cnc_msh_core.sv
// machine state, homing sequencer state and the per-event step logic
`default_nettype none
module cnc_msh_core #(
	parameter int unsigned AXIS_COUNT = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  fire,
	input  wire cnc_msh_pkg::item_t    item,
	input  wire cnc_msh_pkg::cfg_t     cfg,
	output cnc_msh_pkg::result_t       res
);
	import cnc_msh_pkg::*;

	localparam logic [AXIS_W-1:0] AXIS_LIVE = (AXIS_COUNT >= AXIS_W) ? {AXIS_W{1'b1}} :
		AXIS_W'((1 << AXIS_COUNT) - 1);

	mode_t             mode_q, mode_d;
	phase_t            phase_q, phase_d;
	logic [AXIS_W-1:0] pending_q, pending_d;
	logic [AXIS_W-1:0] requested_q, requested_d;
	logic [AIDX_W-1:0] axis_q, axis_d;
	logic [POS_W-1:0]  origin_q, origin_d;

	logic [AXIS_W-1:0] sel_mask;
	logic [AIDX_W-1:0] pick_axis;
	logic [POS_W-1:0]  diff;
	logic [POS_W-1:0]  mag;
	logic              pulloff_reached;
	logic              dir_cur;
	logic              dir_pick;
	logic              hit_cur;

	// bit of a six-bit vector at a three-bit index, zero past the top
	function automatic logic bit_at(input logic [AXIS_W-1:0] v, input logic [AIDX_W-1:0] idx);
		logic [(1<<AIDX_W)-1:0] wide;
		wide = {{((1<<AIDX_W)-AXIS_W){1'b0}}, v};
		return wide[idx];
	endfunction

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		case (m)
			MODE_IDLE:   c = MS_IDLE;
			MODE_RUN:    c = MS_RUN;
			MODE_HOLD:   c = MS_HOLD;
			MODE_HOMING: c = MS_HOMING;
			MODE_ESTOP:  c = MS_ESTOP;
			default:     c = MS_IDLE;
		endcase
		return c;
	endfunction

	assign sel_mask = pending_q & AXIS_LIVE;

	// lowest pending axis
	always_comb begin
		pick_axis = '0;
		for (int i = AXIS_W - 1; i >= 0; i--) begin
			if (sel_mask[i]) pick_axis = AIDX_W'(i);
		end
	end

	assign diff            = origin_q - item.jog_axis_position;
	assign mag             = diff[POS_W-1] ? (POS_W'(0) - diff) : diff;
	assign pulloff_reached = mag >= {{(POS_W-PULL_W){1'b0}}, cfg.pulloff};
	assign dir_cur         = bit_at(cfg.home_dir, axis_q);
	assign dir_pick        = bit_at(cfg.home_dir, pick_axis);
	assign hit_cur         = bit_at(item.limit_switches, axis_q);

	always_comb begin
		mode_d      = mode_q;
		phase_d     = phase_q;
		pending_d   = pending_q;
		requested_d = requested_q;
		axis_d      = axis_q;
		origin_d    = origin_q;
		res         = '0;

		case (item.operation)
			OP_TICK: begin
				if (mode_q == MODE_HOMING) begin
					if (item.stepper_stopped_hard) begin
						res.jog_action     = JOG_STOP;
						mode_d             = MODE_ESTOP;
						res.home_done      = 1'b1;
						res.home_done_mask = requested_q;
						pending_d          = '0;
						phase_d            = PH_SELECT;
					end else begin
						case (phase_q)
							PH_SELECT: begin
								if (sel_mask == '0) begin
									res.zero_positions = 1'b1;
									mode_d             = MODE_IDLE;
									res.home_done      = 1'b1;
									res.home_success   = 1'b1;
									res.home_done_mask = requested_q;
									pending_d          = '0;
									phase_d            = PH_SELECT;
								end else begin
									axis_d           = pick_axis;
									pending_d        = sel_mask & ~(AXIS_W'(1) << pick_axis);
									res.jog_action   = JOG_START;
									res.jog_axis     = pick_axis;
									res.jog_positive = dir_pick;
									res.jog_rate     = cfg.fast_rate;
									phase_d          = PH_FAST;
								end
							end
							PH_FAST: begin
								if (hit_cur) begin
									origin_d         = item.jog_axis_position;
									res.jog_action   = JOG_START;
									res.jog_axis     = axis_q;
									res.jog_positive = ~dir_cur;
									res.jog_rate     = cfg.slow_rate;
									phase_d          = PH_BACKOFF;
								end
							end
							PH_BACKOFF: begin
								if (pulloff_reached) begin
									res.jog_action   = JOG_START;
									res.jog_axis     = axis_q;
									res.jog_positive = dir_cur;
									res.jog_rate     = cfg.slow_rate;
									phase_d          = PH_SLOW;
								end
							end
							default: begin
								if (hit_cur) begin
									res.jog_action = JOG_STOP;
									phase_d        = PH_SELECT;
								end
							end
						endcase
					end
				end else if (mode_q == MODE_IDLE || mode_q == MODE_RUN) begin
					if (item.stepper_done) begin
						if (item.segment_ready) begin
							res.load_segment = 1'b1;
							mode_d           = MODE_RUN;
						end else begin
							mode_d = MODE_IDLE;
						end
					end
				end
			end
			OP_ESTOP: begin
				if (mode_q == MODE_HOMING) begin
					res.jog_action     = JOG_STOP;
					res.home_done      = 1'b1;
					res.home_done_mask = requested_q;
					pending_d          = '0;
					phase_d            = PH_SELECT;
				end
				res.stepper_command = CMD_ESTOP;
				res.clear_queue     = 1'b1;
				mode_d              = MODE_ESTOP;
			end
			OP_RESET: begin
				if (mode_q == MODE_ESTOP) begin
					res.stepper_command = CMD_RESET;
					res.clear_queue     = 1'b1;
					pending_d           = '0;
					phase_d             = PH_SELECT;
					mode_d              = MODE_IDLE;
				end
			end
			OP_HOLD: begin
				if (mode_q == MODE_RUN) begin
					res.stepper_command = CMD_HOLD;
					mode_d              = MODE_HOLD;
				end
			end
			OP_RESUME: begin
				if (mode_q == MODE_HOLD) begin
					res.stepper_command = CMD_RESUME;
					mode_d              = MODE_RUN;
				end
			end
			OP_HOME: begin
				if (mode_q == MODE_IDLE) begin
					pending_d   = item.home_axes;
					requested_d = item.home_axes;
					phase_d     = PH_SELECT;
					mode_d      = MODE_HOMING;
				end
			end
			default: ;
		endcase

		res.machine_state = mode_code(mode_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			phase_q     <= PH_SELECT;
			pending_q   <= '0;
			requested_q <= '0;
			axis_q      <= '0;
			origin_q    <= '0;
		end else if (fire) begin
			mode_q      <= mode_d;
			phase_q     <= phase_d;
			pending_q   <= pending_d;
			requested_q <= requested_d;
			axis_q      <= axis_d;
			origin_q    <= origin_d;
		end
	end

endmodule
`default_nettype wire

// File: src/cnc_motion_state_and_homing.sv
// cnc machine-state controller and limit-switch homing sequencer, top level
//
// Each word on the s_axis channel is one event: s_axis_tuser holds the operation
// (tick, estop, reset, feed hold, resume, home), s_axis_tdata the axis mask, the
// limit switch levels, the jogged axis position and the stepper/planner flags.
// Every accepted word gives exactly one result word on m_axis with the new
// machine state, the jog request, segment load, stepper command, queue clear,
// position zeroing and the homing report.
// Settings come in over the cfg port (index 0 home direction mask, 1 seek rate,
// 2 feed rate, 3 pulloff steps); a rate or distance written as zero uses its
// default. Write settings only while no event is in flight.
// An accepted event is held in the input register, runs through the combinational
// state update and is registered in the result register; one event per cycle
// goes through as long as m_axis does not stall.
// When m_axis stalls the result register holds its word, the input register
// still takes one more event, and s_axis_tready then drops until the result
// is taken. Reset puts the machine in idle with no homing pending and the
// settings at their defaults; no result is pending after reset.
`default_nettype none
module cnc_motion_state_and_homing #(
	parameter int unsigned AXIS_COUNT = 6
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [5:0] home_axes, [11:6] limit_switches, [43:12] jog_axis_position,
	// [44] stepper_stopped_hard, [45] stepper_done, [46] segment_ready
	input  wire logic [47:0] s_axis_tdata,
	// [2:0] operation
	input  wire logic [2:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [2:0] machine_state, [4:3] jog_action, [7:5] jog_axis, [8] jog_positive,
	// [28:9] jog_rate, [29] load_segment, [32:30] stepper_command,
	// [33] clear_queue, [34] zero_positions, [35] home_done,
	// [36] home_success, [42:37] home_done_mask
	output logic [47:0]      m_axis_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);
	import cnc_msh_pkg::*;

	cfg_t    cfg;
	item_t   item_in;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    adv;

	assign cfg_ready = 1'b1;

	cnc_msh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign item_in.operation            = s_axis_tuser;
	assign item_in.home_axes            = s_axis_tdata[5:0];
	assign item_in.limit_switches       = s_axis_tdata[11:6];
	assign item_in.jog_axis_position    = s_axis_tdata[43:12];
	assign item_in.stepper_stopped_hard = s_axis_tdata[44];
	assign item_in.stepper_done         = s_axis_tdata[45];
	assign item_in.segment_ready        = s_axis_tdata[46];

	// move the held word into the result register when that one is free
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_in;
		end
	end

	cnc_msh_core #(
		.AXIS_COUNT (AXIS_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {5'd0, res_s2.home_done_mask, res_s2.home_success, res_s2.home_done,
		res_s2.zero_positions, res_s2.clear_queue, res_s2.stepper_command,
		res_s2.load_segment, res_s2.jog_rate, res_s2.jog_positive, res_s2.jog_axis,
		res_s2.jog_action, res_s2.machine_state};

	// a held event that cannot move on stays held
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("held event lost while result register busy");

	// a stalled result word is not overwritten
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_axis_tready |=> valid_s2 && $stable(res_s2))
		else $error("stalled result changed");

	// homing report fields are quiet unless homing finished
	a_report: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.home_done |-> !res_s2.home_success && res_s2.home_done_mask == '0
			&& !res_s2.zero_positions)
		else $error("homing report without completion");

	// positions are zeroed only on successful completion, back in idle
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.zero_positions |-> res_s2.home_success
			&& res_s2.machine_state == MS_IDLE)
		else $error("zero positions outside successful homing");

endmodule
`default_nettype wire
